// File: rtl/core/hrp_pkg.sv
`default_nettype none
package hrp_pkg;

   localparam int MAX_REQUEST_BYTES = 4096;
   localparam int HEADER_LIMIT      = 32;

   // parse phases
   localparam logic [3:0] PH_METHOD  = 4'd0;
   localparam logic [3:0] PH_PATH    = 4'd1;
   localparam logic [3:0] PH_PARAM   = 4'd2;
   localparam logic [3:0] PH_VERSION = 4'd3;
   localparam logic [3:0] PH_HNAME   = 4'd4;
   localparam logic [3:0] PH_HSKIP   = 4'd5;
   localparam logic [3:0] PH_HVALUE  = 4'd6;
   localparam logic [3:0] PH_BODY    = 4'd7;
   localparam logic [3:0] PH_DRAIN   = 4'd8;

   // event kinds
   localparam logic [2:0] EV_METHOD  = 3'd0;
   localparam logic [2:0] EV_PATH    = 3'd1;
   localparam logic [2:0] EV_PARAM   = 3'd2;
   localparam logic [2:0] EV_VERSION = 3'd3;
   localparam logic [2:0] EV_HEADER  = 3'd4;
   localparam logic [2:0] EV_BODY    = 3'd5;
   localparam logic [2:0] EV_ERROR   = 3'd6;

   // error codes
   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_METHOD    = 3'd1;
   localparam logic [2:0] ERR_LINE      = 3'd2;
   localparam logic [2:0] ERR_VERSION   = 3'd3;
   localparam logic [2:0] ERR_COLON     = 3'd4;
   localparam logic [2:0] ERR_HEADERS   = 3'd5;
   localparam logic [2:0] ERR_PARAMS    = 3'd6;
   localparam logic [2:0] ERR_TRUNCATED = 3'd7;

   // register indexes
   localparam logic [0:0] REG_MAX_HEADERS = 1'd0;
   localparam logic [0:0] REG_MAX_PARAMS  = 1'd1;

   typedef struct packed {
      logic [2:0]  event_kind;
      logic [11:0] span_start;
      logic [12:0] span_length;
      logic [11:0] value_start;
      logic [12:0] value_length;
      logic        has_value;
      logic [2:0]  method_code;
      logic [6:0]  version_value;
      logic [2:0]  error_code;
      logic        run_end;
   } event_type;

   // up to two events per byte
   typedef struct packed {
      logic      valid0;
      event_type ev0;
      logic      valid1;
      event_type ev1;
   } pair_type;

endpackage
`default_nettype wire

// File: rtl/core/hrp_core.sv
`default_nettype none
module hrp_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step,
   input  wire logic [7:0]        byte_in,
   input  wire logic              final_byte,
   input  wire logic [5:0]        max_headers,
   input  wire logic [5:0]        max_params,
   output hrp_pkg::pair_type      pair
);
   import hrp_pkg::*;

   logic [3:0]  phase_ff, phase_in;
   logic [12:0] offset_ff, offset_in;
   logic [11:0] fstart_ff, fstart_in;
   logic [11:0] split_ff, split_in;
   logic        seen_ff, seen_in;
   logic [55:0] mbytes_ff, mbytes_in;
   logic [5:0]  hcount_ff, hcount_in;
   logic [5:0]  pcount_ff, pcount_in;
   logic [6:0]  vdig_ff, vdig_in;
   logic        cr_ff, cr_in;

   logic [2:0]  err;
   logic [12:0] off1;
   logic [12:0] pos;
   logic [11:0] cr_pos, vs;
   logic [5:0]  hlim;
   logic [2:0]  mcode;
   logic        mok;
   logic        is_digit;
   logic [7:0]  tag_byte;
   event_type   e;
   event_type   ee;

   function automatic event_type blank();
      event_type r;
      r = '0;
      return r;
   endfunction

   // method lookup
   always_comb begin
      mok = 1'b1;
      mcode = 3'd0;
      if (offset_ff == 13'd3 && mbytes_ff == 56'h474554) mcode = 3'd0;
      else if (offset_ff == 13'd4 && mbytes_ff == 56'h48454144) mcode = 3'd1;
      else if (offset_ff == 13'd4 && mbytes_ff == 56'h504F5354) mcode = 3'd2;
      else if (offset_ff == 13'd3 && mbytes_ff == 56'h505554) mcode = 3'd3;
      else if (offset_ff == 13'd6 && mbytes_ff == 56'h44454C455445) mcode = 3'd4;
      else if (offset_ff == 13'd7 && mbytes_ff == 56'h434F4E4E454354) mcode = 3'd5;
      else if (offset_ff == 13'd7 && mbytes_ff == 56'h4F5054494F4E53) mcode = 3'd6;
      else if (offset_ff == 13'd5 && mbytes_ff == 56'h5452414345) mcode = 3'd7;
      else mok = 1'b0;
   end

   always_comb begin
      pos = offset_ff - {1'b0, fstart_ff};
      case (pos[2:0])
         3'd0:    tag_byte = 8'h48;
         3'd1:    tag_byte = 8'h54;
         3'd2:    tag_byte = 8'h54;
         3'd3:    tag_byte = 8'h50;
         default: tag_byte = 8'h2F;
      endcase
      is_digit = (byte_in >= 8'h30) && (byte_in <= 8'h39);
      hlim = (max_headers < 6'(HEADER_LIMIT)) ? max_headers : 6'(HEADER_LIMIT);
      off1 = offset_ff + 13'd1;
      cr_pos = offset_ff[11:0] - 12'd1;
      vs = split_ff + 12'd2;
      if (vs > cr_pos) vs = cr_pos;
   end

   // per-byte parse step
   always_comb begin
      phase_in = phase_ff;  offset_in = offset_ff; fstart_in = fstart_ff;
      split_in = split_ff;  seen_in = seen_ff;     mbytes_in = mbytes_ff;
      hcount_in = hcount_ff; pcount_in = pcount_ff; vdig_in = vdig_ff;
      cr_in = cr_ff;
      err = ERR_NONE;
      pair = '0;
      e = blank();
      ee = blank();
      if (phase_ff == PH_DRAIN) begin
         if (final_byte) begin
            phase_in = PH_METHOD; offset_in = '0; fstart_in = '0; split_in = '0;
            seen_in = 1'b0; mbytes_in = '0; hcount_in = '0; pcount_in = '0;
            vdig_in = '0; cr_in = 1'b0;
         end
      end else begin
         if (offset_ff >= 13'(MAX_REQUEST_BYTES)) begin
            err = ERR_TRUNCATED;
         end else if (cr_ff) begin
            if (byte_in != 8'h0A) begin
               err = ERR_LINE;
            end else begin
               cr_in = 1'b0;
               if (phase_ff == PH_VERSION) begin
                  e.event_kind = EV_VERSION;
                  e.span_start = fstart_ff;
                  e.span_length = {1'b0, split_ff - fstart_ff};
                  e.version_value = vdig_ff;
                  pair.valid0 = 1'b1;
               end else if (phase_ff == PH_HVALUE) begin
                  e.event_kind = EV_HEADER;
                  e.span_start = fstart_ff;
                  e.span_length = {1'b0, split_ff - fstart_ff};
                  e.value_start = vs;
                  e.value_length = {1'b0, cr_pos - vs};
                  e.has_value = 1'b1;
                  pair.valid0 = 1'b1;
               end
               phase_in = (phase_ff == PH_HNAME) ? PH_BODY : PH_HNAME;
               fstart_in = off1[11:0];
            end
         end else begin
            case (phase_ff)
               PH_METHOD: begin
                  if (byte_in == 8'h20) begin
                     if (!mok) err = ERR_METHOD;
                     else begin
                        e.event_kind = EV_METHOD;
                        e.span_length = offset_ff;
                        e.method_code = mcode;
                        pair.valid0 = 1'b1;
                        phase_in = PH_PATH;
                        fstart_in = off1[11:0];
                     end
                  end else if (byte_in == 8'h0A) err = ERR_LINE;
                  else if (offset_ff >= 13'd7) err = ERR_METHOD;
                  else mbytes_in = {mbytes_ff[47:0], byte_in};
               end
               PH_PATH: begin
                  if (byte_in == 8'h3F || byte_in == 8'h20) begin
                     e.event_kind = EV_PATH;
                     e.span_start = fstart_ff;
                     e.span_length = offset_ff - {1'b0, fstart_ff};
                     pair.valid0 = 1'b1;
                     phase_in = (byte_in == 8'h3F) ? PH_PARAM : PH_VERSION;
                     fstart_in = off1[11:0];
                     seen_in = 1'b0;
                     vdig_in = '0;
                  end else if (byte_in == 8'h0A) err = ERR_LINE;
               end
               PH_PARAM: begin
                  if (byte_in == 8'h3D && !seen_ff) begin
                     seen_in = 1'b1;
                     split_in = offset_ff[11:0];
                  end else if (byte_in == 8'h26 || byte_in == 8'h20) begin
                     if (pcount_ff >= max_params) err = ERR_PARAMS;
                     else begin
                        e.event_kind = EV_PARAM;
                        e.span_start = fstart_ff;
                        if (seen_ff) begin
                           e.span_length = {1'b0, split_ff - fstart_ff};
                           e.value_start = split_ff + 12'd1;
                           e.value_length = offset_ff - {1'b0, split_ff} - 13'd1;
                           e.has_value = 1'b1;
                        end else begin
                           e.span_length = offset_ff - {1'b0, fstart_ff};
                        end
                        pair.valid0 = 1'b1;
                        pcount_in = pcount_ff + 6'd1;
                        fstart_in = off1[11:0];
                        seen_in = 1'b0;
                        if (byte_in == 8'h20) begin
                           phase_in = PH_VERSION;
                           vdig_in = '0;
                        end
                     end
                  end else if (byte_in == 8'h0A) err = ERR_LINE;
               end
               PH_VERSION: begin
                  if (byte_in == 8'h0A) err = ERR_LINE;
                  else if (byte_in == 8'h0D) begin
                     if (pos < 13'd8) err = ERR_VERSION;
                     else begin
                        cr_in = 1'b1;
                        split_in = offset_ff[11:0];
                     end
                  end else if (pos < 13'd5) begin
                     if (byte_in != tag_byte) err = ERR_VERSION;
                  end else if (pos == 13'd5 || pos == 13'd7) begin
                     if (!is_digit) err = ERR_VERSION;
                     else if (pos == 13'd5)
                        vdig_in = 7'((byte_in - 8'h30) * 8'd10);
                     else vdig_in = vdig_ff + 7'(byte_in - 8'h30);
                  end
               end
               PH_HNAME: begin
                  if (byte_in == 8'h3A) begin
                     if (hcount_ff >= hlim) err = ERR_HEADERS;
                     else begin
                        hcount_in = hcount_ff + 6'd1;
                        split_in = offset_ff[11:0];
                        phase_in = PH_HSKIP;
                     end
                  end else if (byte_in == 8'h0D) begin
                     if (offset_ff == {1'b0, fstart_ff}) cr_in = 1'b1;
                     else err = ERR_COLON;
                  end else if (byte_in == 8'h0A) err = ERR_LINE;
               end
               PH_HSKIP: begin
                  if (byte_in == 8'h0A) err = ERR_LINE;
                  else begin
                     if (byte_in == 8'h0D) cr_in = 1'b1;
                     phase_in = PH_HVALUE;
                  end
               end
               PH_HVALUE: begin
                  if (byte_in == 8'h0D) cr_in = 1'b1;
                  else if (byte_in == 8'h0A) err = ERR_LINE;
               end
               default: ;
            endcase
         end

         if (err != ERR_NONE) begin
            ee.event_kind = EV_ERROR;
            ee.span_start = offset_ff[11:0];
            ee.error_code = err;
            ee.run_end = 1'b1;
            pair.valid1 = 1'b1;
            phase_in = PH_DRAIN;
         end else begin
            offset_in = off1;
            if (final_byte) begin
               if (phase_in == PH_BODY && !cr_in) begin
                  // body entered on this byte is empty
                  ee.event_kind = EV_BODY;
                  ee.span_start = fstart_in;
                  ee.span_length = (phase_ff == PH_BODY) ?
                                   off1 - {1'b0, fstart_ff} : 13'd0;
               end else begin
                  ee.event_kind = EV_ERROR;
                  ee.span_start = offset_ff[11:0];
                  ee.error_code = ERR_TRUNCATED;
               end
               ee.run_end = 1'b1;
               pair.valid1 = 1'b1;
            end
         end
         if (final_byte) begin
            phase_in = PH_METHOD; offset_in = '0; fstart_in = '0; split_in = '0;
            seen_in = 1'b0; mbytes_in = '0; hcount_in = '0; pcount_in = '0;
            vdig_in = '0; cr_in = 1'b0;
         end
      end
      pair.ev0 = e;
      pair.ev1 = ee;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_METHOD; offset_ff <= '0; fstart_ff <= '0; split_ff <= '0;
         seen_ff <= 1'b0; mbytes_ff <= '0; hcount_ff <= '0; pcount_ff <= '0;
         vdig_ff <= '0; cr_ff <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in; offset_ff <= offset_in; fstart_ff <= fstart_in;
         split_ff <= split_in; seen_ff <= seen_in; mbytes_ff <= mbytes_in;
         hcount_ff <= hcount_in; pcount_ff <= pcount_in; vdig_ff <= vdig_in;
         cr_ff <= cr_in;
      end
   end
endmodule
`default_nettype wire

// File: rtl/core/hrp_outq.sv
`default_nettype none
module hrp_outq (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire hrp_pkg::pair_type pair,
   output logic                   room,
   output logic                   out_valid,
   output hrp_pkg::event_type     out_event,
   input  wire logic              out_stall
);
   import hrp_pkg::*;

   // four-entry event queue; a byte needs two free slots
   event_type  q_ff [4];
   logic [1:0] rd_ff, wr_ff;
   logic [2:0] cnt_ff, cnt_in;
   logic       pop;
   logic [1:0] n_push;

   assign room      = (cnt_ff <= 3'd2) || (cnt_ff == 3'd3 && !out_stall);
   assign out_valid = (cnt_ff != 3'd0);
   assign out_event = q_ff[rd_ff];
   assign pop       = out_valid && !out_stall;
   assign n_push    = push ? (2'(pair.valid0) + 2'(pair.valid1)) : 2'd0;
   assign cnt_in    = cnt_ff + 3'(n_push) - 3'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff <= '0; wr_ff <= '0; cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff  <= rd_ff + 2'(pop);
         wr_ff  <= wr_ff + n_push;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         if (pair.valid0) begin
            q_ff[wr_ff] <= pair.ev0;
            if (pair.valid1) q_ff[wr_ff + 2'd1] <= pair.ev1;
         end else if (pair.valid1) begin
            q_ff[wr_ff] <= pair.ev1;
         end
      end
   end
endmodule
`default_nettype wire

// File: rtl/core/http_request_header_parser_unit.sv
`default_nettype none
// HTTP request parser: one request byte per word, final_byte on the last.
// Emits method, path, param, version, header and body span events, or an
// error event that ends the request. Each byte is parsed by the parse
// stage and its zero to two events go into a four-entry queue, so a byte
// is taken every cycle while the result side keeps pace; req_stall rises
// only when the queue lacks room for two events.
module http_request_header_parser_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_byte_in,
   input  wire logic        req_final_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_event_kind,
   output logic [11:0]      rsp_span_start,
   output logic [12:0]      rsp_span_length,
   output logic [11:0]      rsp_value_start,
   output logic [12:0]      rsp_value_length,
   output logic             rsp_has_value,
   output logic [2:0]       rsp_method_code,
   output logic [6:0]       rsp_version_value,
   output logic [2:0]       rsp_error_code,
   output logic             rsp_run_end,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [0:0]  csr_index,
   input  wire logic [5:0]  csr_data
);
   import hrp_pkg::*;

   logic [5:0] max_headers_ff, max_params_ff;
   logic       room, step;
   pair_type   pair;
   event_type  ev;

   assign csr_ready = 1'b1;
   assign req_stall = !room;
   assign step      = req_valid && room;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_headers_ff <= 6'd16;
         max_params_ff  <= 6'd16;
      end else if (csr_valid) begin
         case (csr_index)
            REG_MAX_HEADERS: max_headers_ff <= csr_data;
            REG_MAX_PARAMS:  max_params_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   hrp_core u_core (
      .clock(clock), .reset(reset), .step(step),
      .byte_in(req_byte_in), .final_byte(req_final_byte),
      .max_headers(max_headers_ff), .max_params(max_params_ff), .pair(pair)
   );

   hrp_outq u_outq (
      .clock(clock), .reset(reset), .push(step), .pair(pair), .room(room),
      .out_valid(rsp_valid), .out_event(ev), .out_stall(rsp_stall)
   );

   assign rsp_event_kind    = ev.event_kind;
   assign rsp_span_start    = ev.span_start;
   assign rsp_span_length   = ev.span_length;
   assign rsp_value_start   = ev.value_start;
   assign rsp_value_length  = ev.value_length;
   assign rsp_has_value     = ev.has_value;
   assign rsp_method_code   = ev.method_code;
   assign rsp_version_value = ev.version_value;
   assign rsp_error_code    = ev.error_code;
   assign rsp_run_end       = ev.run_end;
endmodule
`default_nettype wire
